// File: rtl/adlmu_pkg.sv
// shared constants, types and modulo helpers for the adler-32 multibyte update block
package adlmu_pkg;

  localparam int unsigned LANES      = 16;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SEED_W     = 32;
  localparam int unsigned BYTES_W    = 64;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned WPROD_W    = 8 + CNT_W;
  localparam int unsigned BSUM_W     = $clog2(LANES * 255 + 1);
  localparam int unsigned WSUM_W     = $clog2(255 * LANES * (LANES + 1) / 2 + 1);
  localparam int unsigned ACC1_W     = SUM_W + 1;
  localparam int unsigned PROD_W     = SUM_W + CNT_W;
  localparam int unsigned ACC2_W     = PROD_W + 1;
  localparam int unsigned ADLER_MOD  = 65521;
  localparam int unsigned FOLD       = 65536 - ADLER_MOD;

  typedef struct packed {
    logic                start;
    logic [SEED_W-1:0]   seed;
    logic [CNT_W-1:0]    count;
    logic [BSUM_W-1:0]   byte_sum;
    logic [WSUM_W-1:0]   wsum;
  } lane_sum_t;

  // value below twice the modulus
  function automatic logic [SUM_W-1:0] mod_fold1(input logic [ACC1_W-1:0] x);
    logic [ACC1_W-1:0] m;
    m = ACC1_W'(ADLER_MOD);
    if (x >= m) begin
      return SUM_W'(x - m);
    end
    return x[SUM_W-1:0];
  endfunction

  // 2^16 is congruent to 15, fold the upper bits down then subtract once
  function automatic logic [SUM_W-1:0] mod_fold2(input logic [ACC2_W-1:0] x);
    logic [ACC1_W-1:0] y;
    y = ACC1_W'(x[SUM_W-1:0]) + ACC1_W'(x[ACC2_W-1:SUM_W]) * ACC1_W'(FOLD);
    return mod_fold1(y);
  endfunction

endpackage

// File: rtl/adlmu_in_if.sv
// input channel: one word of up to sixteen bytes plus start and seed
interface adlmu_in_if;
  import adlmu_pkg::*;

  logic               valid;
  logic               ready;
  logic               start_req;
  logic [SEED_W-1:0]  seed;
  logic [BYTES_W-1:0] bytes_low;
  logic [BYTES_W-1:0] bytes_high;
  logic [CNT_W-1:0]   byte_count;

  modport source (output valid, output start_req, output seed, output bytes_low,
                  output bytes_high, output byte_count, input ready);
  modport sink   (input valid, input start_req, input seed, input bytes_low,
                  input bytes_high, input byte_count, output ready);
endinterface

// File: rtl/adlmu_out_if.sv
// output channel: running checksum word
interface adlmu_out_if;
  import adlmu_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEED_W-1:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

// File: rtl/adlmu_lane.sv
// one byte lane: masks the byte and weights it by its distance from the word end
module adlmu_lane (
  input  logic [7:0]                   byte_i,
  input  logic [adlmu_pkg::CNT_W-1:0]  lane_i,
  input  logic [adlmu_pkg::CNT_W-1:0]  count_i,
  output logic [7:0]                   byte_o,
  output logic [adlmu_pkg::WPROD_W-1:0] wbyte_o
);
  import adlmu_pkg::*;

  logic             active;
  logic [CNT_W-1:0] weight;

  assign active  = lane_i < count_i;
  assign weight  = count_i - lane_i;
  assign byte_o  = active ? byte_i : 8'd0;
  assign wbyte_o = active ? WPROD_W'(byte_i) * WPROD_W'(weight) : '0;

endmodule

// File: rtl/adlmu_merge.sv
// merges lane results into the byte total and the weighted total
module adlmu_merge (
  input  logic [7:0]                    byte_i  [adlmu_pkg::LANES],
  input  logic [adlmu_pkg::WPROD_W-1:0] wbyte_i [adlmu_pkg::LANES],
  output logic [adlmu_pkg::BSUM_W-1:0]  byte_sum_o,
  output logic [adlmu_pkg::WSUM_W-1:0]  wsum_o
);
  import adlmu_pkg::*;

  always_comb begin
    logic [BSUM_W-1:0] bsum;
    logic [WSUM_W-1:0] wsum;
    bsum = '0;
    wsum = '0;
    for (int i = 0; i < LANES; i++) begin
      bsum = bsum + BSUM_W'(byte_i[i]);
      wsum = wsum + WSUM_W'(wbyte_i[i]);
    end
    byte_sum_o = bsum;
    wsum_o     = wsum;
  end

endmodule

// File: rtl/adlmu_accum.sv
// running sums: seed load, add lane totals, reduce modulo 65521
module adlmu_accum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  adlmu_pkg::lane_sum_t         stage_i,
  output logic [adlmu_pkg::SEED_W-1:0] checksum_o
);
  import adlmu_pkg::*;

  logic [SUM_W-1:0]  low_q, low_d;
  logic [SUM_W-1:0]  high_q, high_d;
  logic [SUM_W-1:0]  base1, base2;
  logic [ACC1_W-1:0] acc1;
  logic [PROD_W-1:0] prod;
  logic [ACC2_W-1:0] acc2;

  assign base1 = stage_i.start ? stage_i.seed[SUM_W-1:0] : low_q;
  assign base2 = stage_i.start ? stage_i.seed[SEED_W-1:SUM_W] : high_q;
  assign acc1  = ACC1_W'(base1) + ACC1_W'(stage_i.byte_sum);
  assign prod  = PROD_W'(stage_i.count) * PROD_W'(base1);
  assign acc2  = ACC2_W'(base2) + ACC2_W'(prod) + ACC2_W'(stage_i.wsum);

  always_comb begin
    if (stage_i.count != '0) begin
      low_d  = mod_fold1(acc1);
      high_d = mod_fold2(acc2);
    end else begin
      low_d  = base1;
      high_d = base2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= SUM_W'(1);
      high_q <= '0;
    end else if (upd_i) begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign checksum_o = {high_q, low_q};

endmodule

// File: rtl/adler32_multibyte_update_top.sv
// top level of the adler-32 multibyte update block
//
//  channel | dir | payload                                            | handshake
//  in_i    | in  | start_req, seed, bytes_low, bytes_high, byte_count  | valid/ready
//  out_o   | out | checksum                                           | valid/ready
//
// one word per cycle unless out_o stalls; checksum via lane stage and sum registers
// cycle time is set by the sum loop: one 5x16 multiply, a three-way add, fold mod 65521
// reset puts the sums at 1 and 0, no clearing pass, words taken on the next cycle
// a stalled output holds its word while one more input word waits in the lane stage

module adler32_multibyte_update_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  adlmu_in_if.sink     in_i,
  adlmu_out_if.source  out_o
);
  import adlmu_pkg::*;

  logic [7:0]         lane_byte [LANES];
  logic [7:0]         mbyte     [LANES];
  logic [WPROD_W-1:0] wbyte     [LANES];
  logic [CNT_W-1:0]   cnt_sat;
  logic [BSUM_W-1:0]  byte_sum;
  logic [WSUM_W-1:0]  wsum;

  lane_sum_t stage_q, stage_d;
  logic      s1_valid_q, s1_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free, adv, in_fire;

  assign cnt_sat = (in_i.byte_count > CNT_W'(LANES)) ? CNT_W'(LANES) : in_i.byte_count;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < 8) begin : g_lo
      assign lane_byte[i] = in_i.bytes_low[8*i +: 8];
    end else begin : g_hi
      assign lane_byte[i] = in_i.bytes_high[8*(i-8) +: 8];
    end

    adlmu_lane u_lane (
      .byte_i  (lane_byte[i]),
      .lane_i  (CNT_W'(i)),
      .count_i (cnt_sat),
      .byte_o  (mbyte[i]),
      .wbyte_o (wbyte[i])
    );
  end

  adlmu_merge u_merge (
    .byte_i     (mbyte),
    .wbyte_i    (wbyte),
    .byte_sum_o (byte_sum),
    .wsum_o     (wsum)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    stage_d.start    = in_i.start_req;
    stage_d.seed     = in_i.seed;
    stage_d.count    = cnt_sat;
    stage_d.byte_sum = byte_sum;
    stage_d.wsum     = wsum;
  end

  assign s1_valid_d  = in_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_q <= stage_d;
    end
  end

  adlmu_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (adv),
    .stage_i    (stage_q),
    .checksum_o (out_o.checksum)
  );

  assign out_o.valid = out_valid_q;

  // lane stage word is kept while the output is blocked
  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q)
    else $error("lane stage word lost while output stalled");

  a_take_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted word missing from lane stage");

  a_adv_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_o.valid)
    else $error("updated checksum not presented");

  a_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (stage_q.count != '0) |=>
      (out_o.checksum[SUM_W-1:0] < SUM_W'(ADLER_MOD)) &&
      (out_o.checksum[SEED_W-1:SUM_W] < SUM_W'(ADLER_MOD)))
    else $error("sums not reduced after nonempty word");

endmodule

// File: bench/tb_adler32_multibyte_update_top.sv
// testbench for the adler-32 multibyte update block: scoreboard predicts every checksum word
`timescale 1ns / 1ps

module tb_adler32_multibyte_update_top;
  import adlmu_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_WORDS = 880;
  localparam int unsigned STEADY_FROM  = 250;
  localparam int unsigned STEADY_TO    = 450;
  localparam int unsigned HOLD_AT      = 600;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 8;

  class adler_scoreboard;
    logic [SUM_W-1:0]  sum_a;
    logic [SUM_W-1:0]  sum_b;
    logic [SEED_W-1:0] expected_checksums[$];
    int unsigned       fails;

    function new();
      sum_a = SUM_W'(1);
      sum_b = '0;
      fails = 0;
    endfunction

    function void note_word(logic start, logic [SEED_W-1:0] seed, logic [BYTES_W-1:0] lo,
                            logic [BYTES_W-1:0] hi, logic [CNT_W-1:0] cnt);
      logic [31:0]            s1;
      logic [31:0]            s2;
      logic [2*BYTES_W-1:0]   lanes;
      int unsigned            n;
      if (start) begin
        sum_a = seed[SUM_W-1:0];
        sum_b = seed[SEED_W-1:SUM_W];
      end
      n = (cnt > LANES) ? LANES : int'(cnt);
      if (n != 0) begin
        lanes = {hi, lo};
        s1 = 32'(sum_a);
        s2 = 32'(sum_b);
        for (int unsigned i = 0; i < n; i++) begin
          s1 = s1 + 32'(lanes[8*i +: 8]);
          s2 = s2 + s1;
        end
        sum_a = SUM_W'(s1 % ADLER_MOD);
        sum_b = SUM_W'(s2 % ADLER_MOD);
      end
      expected_checksums.push_back({sum_b, sum_a});
    endfunction

    function void check_checksum(logic [SEED_W-1:0] actual);
      logic [SEED_W-1:0] expected;
      if (expected_checksums.size() == 0) begin
        $display("%0t unexpected checksum word: expected none actual %h", $time, actual);
        fails++;
      end else begin
        expected = expected_checksums.pop_front();
        if (actual !== expected) begin
          $display("%0t checksum mismatch: expected %h actual %h", $time, expected, actual);
          fails++;
        end
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  int unsigned     words_taken;
  int unsigned     cycles;
  adler_scoreboard sb = new();

  adlmu_in_if  in_if ();
  adlmu_out_if out_if ();

  adler32_multibyte_update_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bit steady_stretch();
    return words_taken >= STEADY_FROM && words_taken < STEADY_TO;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_word(in_if.start_req, in_if.seed, in_if.bytes_low, in_if.bytes_high,
                   in_if.byte_count);
      words_taken <= words_taken + 1;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_checksum(out_if.checksum);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // random receiver with one long hold-off so the block backs up into its input
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_taken >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (steady_stretch()) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 18);
      end
    end
  end

  task automatic send_word(bit st, logic [SEED_W-1:0] sd, logic [BYTES_W-1:0] lo,
                           logic [BYTES_W-1:0] hi, logic [CNT_W-1:0] cnt);
    if (!steady_stretch()) begin
      while ($urandom_range(99) < 18) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.start_req  <= st;
    in_if.seed       <= sd;
    in_if.bytes_low  <= lo;
    in_if.bytes_high <= hi;
    in_if.byte_count <= cnt;
    do @(posedge clk); while (!in_if.ready);
  endtask

  function automatic logic [BYTES_W-1:0] pick_bytes();
    case ($urandom_range(9))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [SEED_W-1:0] pick_seed();
    case ($urandom_range(3))
      0:       return {16'($urandom_range(65535, ADLER_MOD)),
                       16'($urandom_range(65535, ADLER_MOD))};
      1:       return $urandom;
      default: return {16'($urandom_range(ADLER_MOD - 1)), 16'($urandom_range(ADLER_MOD - 1))};
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) begin
      return CNT_W'(LANES);
    end else if (r < 90) begin
      return CNT_W'($urandom_range(LANES));
    end
    return CNT_W'($urandom_range(31, LANES + 1));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned msg_len;
    bit          with_start;
    rst_n = 1'b0;
    words_taken = 0;
    cycles = 0;
    in_if.valid      <= 1'b0;
    in_if.start_req  <= 1'b0;
    in_if.seed       <= '0;
    in_if.bytes_low  <= '0;
    in_if.bytes_high <= '0;
    in_if.byte_count <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed words
    send_word(1'b0, '0, '1, '1, 5'd16);
    send_word(1'b0, '0, '1, '1, 5'd0);
    send_word(1'b1, '1, '0, '0, 5'd0);
    send_word(1'b0, '0, 64'hff, '0, 5'd1);
    send_word(1'b1, 32'hfff0fff0, '1, '1, 5'd16);
    send_word(1'b1, 32'hfff1fff1, '0, '0, 5'd0);
    send_word(1'b0, '1, '0, '0, 5'd16);
    send_word(1'b1, '0, '1, '1, 5'd31);
    send_word(1'b0, '0, '1, '1, 5'd17);
    send_word(1'b0, '0, '1, '1, 5'd5);
    send_word(1'b0, '0, 64'h55aa55aa55aa55aa, 64'haa55aa55aa55aa55, 5'd8);
    send_word(1'b0, '0, 64'haa55aa55aa55aa55, 64'h55aa55aa55aa55aa, 5'd16);
    send_word(1'b1, 32'h0000ffff, 64'h1, '0, 5'd1);
    send_word(1'b1, 32'hffff0000, '0, 64'h8080808080808080, 5'd16);
    send_word(1'b1, 32'h00000001, '1, '1, 5'd16);
    repeat (4) send_word(1'b0, '0, '1, '1, 5'd16);
    send_word(1'b1, 32'h12345678, '1, '1, 5'd15);

    // random messages
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      msg_len = $urandom_range(24, 1);
      with_start = ($urandom_range(9) != 0);
      for (int unsigned k = 0; k < msg_len; k++) begin
        send_word(with_start && k == 0, pick_seed(), pick_bytes(), pick_bytes(), pick_count());
        sent++;
      end
    end
    in_if.valid <= 1'b0;

    while (sb.expected_checksums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/adlmu_pkg.sv
rtl/adlmu_in_if.sv
rtl/adlmu_out_if.sv
rtl/adlmu_lane.sv
rtl/adlmu_merge.sv
rtl/adlmu_accum.sv
rtl/adler32_multibyte_update_top.sv
bench/tb_adler32_multibyte_update_top.sv
